// ----- rtl/core/avr_pkg.sv -----
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants of the axis vector rotator
// Fixed-point formats, transaction payloads, the axis codes and the
// arctangent table used by the CORDIC cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package avr_pkg;

	// coordinate and angle formats
	localparam int COORD_W  = 32;              // Q16.16 coordinates
	localparam int ANG_W    = 32;              // Q4.28 radians
	localparam int GUARD    = 8;               // guard bits below the coordinate lsb
	localparam int PAIR_W   = COORD_W + 1;     // coordinate with room for negation
	localparam int DATA_W   = COORD_W + GUARD + 3;
	localparam int RED_W    = ANG_W + 2;       // headroom for angle reduction
	localparam int GAIN_W   = 31;
	localparam int GAIN_SHR = 30 - GUARD;

	localparam logic signed [ANG_W-1:0]  ANG_TWO_PI  = 32'sd1686629713;
	localparam logic signed [ANG_W-1:0]  ANG_PI      = 32'sd843314857;
	localparam logic signed [ANG_W-1:0]  ANG_HALF_PI = 32'sd421657428;
	// 0.6072529350 in Q1.30
	localparam logic signed [GAIN_W-1:0] GAIN_Q30    = 31'sd652032874;

	// rotation axis codes
	typedef enum logic [1:0] {
		CMD_ROT_X = 2'd0,
		CMD_ROT_Y = 2'd1,
		CMD_ROT_Z = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// input transaction
	typedef struct packed {
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
		logic signed [COORD_W-1:0] z_in;
		logic signed [ANG_W-1:0]   angle;
		logic [1:0]                command;
	} point_t;

	// output transaction
	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
		logic signed [COORD_W-1:0] z_out;
		logic                      clipped;
	} result_t;

	// plane pair and residual angle handed from cell to cell
	typedef struct packed {
		logic signed [DATA_W-1:0] u;
		logic signed [DATA_W-1:0] v;
		logic signed [ANG_W-1:0]  ang;
	} vec_t;

	// original point and axis code riding alongside the pair
	typedef struct packed {
		cmd_t                      cmd;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} side_t;

	// atan(2^-idx) in Q4.28, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
		logic signed [ANG_W-1:0] a;
		unique case (idx)
			0:       a = 32'sd210828714;
			1:       a = 32'sd124459457;
			2:       a = 32'sd65760959;
			3:       a = 32'sd33381290;
			4:       a = 32'sd16755422;
			5:       a = 32'sd8385879;
			6:       a = 32'sd4193963;
			7:       a = 32'sd2097109;
			8:       a = 32'sd1048571;
			9:       a = 32'sd524287;
			10:      a = 32'sd262144;
			11:      a = 32'sd131072;
			12:      a = 32'sd65536;
			13:      a = 32'sd32768;
			14:      a = 32'sd16384;
			15:      a = 32'sd8192;
			16:      a = 32'sd4096;
			17:      a = 32'sd2048;
			18:      a = 32'sd1024;
			19:      a = 32'sd512;
			20:      a = 32'sd256;
			21:      a = 32'sd128;
			22:      a = 32'sd64;
			23:      a = 32'sd32;
			24:      a = 32'sd16;
			25:      a = 32'sd8;
			26:      a = 32'sd4;
			27:      a = 32'sd2;
			28:      a = 32'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/core/avr_prep.sv -----
// ----------------------------------------------------------------------------
// avr_prep: angle reduction, quadrant fold and gain compensation
// Three pipeline stages ahead of the CORDIC cell row: bring the angle into
// (-pi, pi], fold it into [-pi/2, pi/2], then scale the pair by the CORDIC gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avr_prep import avr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  point_t  in_data,
	output logic    out_valid,
	output vec_t    out_vec,
	output side_t   out_side
);

	localparam logic signed [RED_W-1:0] RED_PI     = RED_W'(ANG_PI);
	localparam logic signed [RED_W-1:0] RED_TWO_PI = RED_W'(ANG_TWO_PI);
	localparam int PROD_W = PAIR_W + GAIN_W;

	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [PAIR_W-1:0]  u_s1, v_s1, u_s2, v_s2;
	logic signed [ANG_W-1:0]   ang_s1, ang_s2, ang_s3;
	logic signed [DATA_W-1:0]  u_s3, v_s3;
	side_t                     side_s1, side_s2, side_s3;

	logic signed [RED_W-1:0]   ang_ext;
	logic signed [RED_W-1:0]   ang_red;
	logic signed [PAIR_W-1:0]  u_sel, v_sel;
	logic signed [PAIR_W-1:0]  u_fold, v_fold;
	logic signed [ANG_W-1:0]   ang_fold;
	logic signed [PROD_W-1:0]  prod_u, prod_v;
	logic signed [PROD_W-1:0]  scl_u, scl_v;
	side_t                     side_in;

	// stage 1: reduce the angle by one turn where needed, pick the plane pair
	// a negative angle whose turn-up lands exactly on pi keeps that pi
	always_comb begin
		ang_ext = {{(RED_W-ANG_W){in_data.angle[ANG_W-1]}}, in_data.angle};
		priority if (ang_ext > RED_PI) begin
			ang_red = ang_ext - RED_TWO_PI;
		end else if (ang_ext <= RED_PI - RED_TWO_PI) begin
			ang_red = ang_ext + RED_TWO_PI;
		end else begin
			ang_red = ang_ext;
		end

		side_in.cmd = cmd_t'(in_data.command);
		side_in.x   = in_data.x_in;
		side_in.y   = in_data.y_in;
		side_in.z   = in_data.z_in;

		unique case (side_in.cmd)
			CMD_ROT_X: begin
				u_sel = {in_data.y_in[COORD_W-1], in_data.y_in};
				v_sel = {in_data.z_in[COORD_W-1], in_data.z_in};
			end
			CMD_ROT_Y: begin
				u_sel = {in_data.x_in[COORD_W-1], in_data.x_in};
				v_sel = {in_data.z_in[COORD_W-1], in_data.z_in};
			end
			CMD_ROT_Z, CMD_NONE: begin
				u_sel = {in_data.x_in[COORD_W-1], in_data.x_in};
				v_sel = {in_data.y_in[COORD_W-1], in_data.y_in};
			end
		endcase
	end

	// stage 2: quarter-turn fold so the cell row only sees [-pi/2, pi/2]
	always_comb begin
		priority if (ang_s1 > ANG_HALF_PI) begin
			u_fold   = -v_s1;
			v_fold   = u_s1;
			ang_fold = ang_s1 - ANG_HALF_PI;
		end else if (ang_s1 < -ANG_HALF_PI) begin
			u_fold   = v_s1;
			v_fold   = -u_s1;
			ang_fold = ang_s1 + ANG_HALF_PI;
		end else begin
			u_fold   = u_s1;
			v_fold   = v_s1;
			ang_fold = ang_s1;
		end
	end

	// stage 3: gain compensation, keeping the guard bits
	assign prod_u = u_s2 * GAIN_Q30;
	assign prod_v = v_s2 * GAIN_Q30;
	assign scl_u  = prod_u >>> GAIN_SHR;
	assign scl_v  = prod_v >>> GAIN_SHR;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= u_sel;
			v_s1    <= v_sel;
			ang_s1  <= ang_red[ANG_W-1:0];
			side_s1 <= side_in;
			u_s2    <= u_fold;
			v_s2    <= v_fold;
			ang_s2  <= ang_fold;
			side_s2 <= side_s1;
			u_s3    <= scl_u[DATA_W-1:0];
			v_s3    <= scl_v[DATA_W-1:0];
			ang_s3  <= ang_s2;
			side_s3 <= side_s2;
		end
	end

	assign out_valid   = valid_s3;
	assign out_vec.u   = u_s3;
	assign out_vec.v   = v_s3;
	assign out_vec.ang = ang_s3;
	assign out_side    = side_s3;

endmodule

// ----- rtl/core/avr_cell.sv -----
// ----------------------------------------------------------------------------
// avr_cell: one CORDIC micro-rotation
// Rotates the pair by +/- atan(2^-STAGE) toward a zero residual angle and
// registers the result for the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avr_cell import avr_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  vec_t  in_vec,
	input  side_t in_side,
	output logic  out_valid,
	output vec_t  out_vec,
	output side_t out_side
);

	localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STAGE);

	logic                     valid_q;
	vec_t                     vec_q;
	side_t                    side_q;
	logic signed [DATA_W-1:0] du, dv;
	vec_t                     vec_nxt;

	// shift-and-add rotation, direction from the residual sign
	always_comb begin
		du = in_vec.v >>> STAGE;
		dv = in_vec.u >>> STAGE;
		if (!in_vec.ang[ANG_W-1]) begin
			vec_nxt.u   = in_vec.u - du;
			vec_nxt.v   = in_vec.v + dv;
			vec_nxt.ang = in_vec.ang - ATAN;
		end else begin
			vec_nxt.u   = in_vec.u + du;
			vec_nxt.v   = in_vec.v - dv;
			vec_nxt.ang = in_vec.ang + ATAN;
		end
	end

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (en) begin
			vec_q  <= vec_nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_vec   = vec_q;
	assign out_side  = side_q;

endmodule

// ----- rtl/core/avr_post.sv -----
// ----------------------------------------------------------------------------
// avr_post: rounding, saturation and point reassembly
// Drops the guard bits with round half up, clamps to the coordinate range and
// puts the rotated pair back next to the untouched axis coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avr_post import avr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  vec_t    in_vec,
	input  side_t   in_side,
	output logic    out_valid,
	output result_t out_data
);

	localparam logic signed [DATA_W-1:0]  RND    = DATA_W'(1) <<< (GUARD - 1);
	localparam logic signed [COORD_W-1:0] SAT_HI = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] SAT_LO = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic                      clip;
		logic signed [COORD_W-1:0] value;
	} sat_t;

	function automatic sat_t round_sat(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] sum;
		logic signed [DATA_W-1:0] rs;
		sat_t                     o;
		sum = v + RND;
		rs  = sum >>> GUARD;
		if (rs[DATA_W-1:COORD_W-1] == {(DATA_W-COORD_W+1){rs[DATA_W-1]}}) begin
			o.clip  = 1'b0;
			o.value = rs[COORD_W-1:0];
		end else begin
			o.clip  = 1'b1;
			o.value = rs[DATA_W-1] ? SAT_LO : SAT_HI;
		end
		return o;
	endfunction

	logic    valid_q;
	result_t data_q;
	sat_t    su, sv;
	result_t data_nxt;

	// put the pair back on its axes
	always_comb begin
		su = round_sat(in_vec.u);
		sv = round_sat(in_vec.v);
		data_nxt.x_out   = in_side.x;
		data_nxt.y_out   = in_side.y;
		data_nxt.z_out   = in_side.z;
		data_nxt.clipped = 1'b0;
		unique case (in_side.cmd)
			CMD_ROT_X: begin
				data_nxt.y_out   = su.value;
				data_nxt.z_out   = sv.value;
				data_nxt.clipped = su.clip | sv.clip;
			end
			CMD_ROT_Y: begin
				data_nxt.x_out   = su.value;
				data_nxt.z_out   = sv.value;
				data_nxt.clipped = su.clip | sv.clip;
			end
			CMD_ROT_Z: begin
				data_nxt.x_out   = su.value;
				data_nxt.y_out   = sv.value;
				data_nxt.clipped = su.clip | sv.clip;
			end
			CMD_NONE: begin
				data_nxt.clipped = 1'b0;
			end
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- rtl/core/axis_vector_rotator.sv -----
// ----------------------------------------------------------------------------
// axis_vector_rotator: rotates a Q16.16 point about the x, y or z axis
// Takes one point per clock on the pt channel while pt_ready is high and returns
// one rotated point per clock on the res channel while res_ready is high, in order.
// Between pt acceptance and res valid the point passes three preparation stages,
// one cell per CORDIC stage, one rounding stage and the output register; each
// CORDIC cell performs one micro-rotation.
// Angles in Q4.28 radians are reduced modulo 2*pi, so any input code is legal.
// Axis code 3 passes the point through unchanged. While res_ready is low the
// output register plus a one-entry skid buffer absorb the transaction in
// flight, and pt_ready drops only once the skid buffer holds data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_vector_rotator import avr_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pt_valid,
	output logic    pt_ready,
	input  point_t  pt_data,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);

	localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic    en;
	logic    push;
	logic    chain_valid [CORDIC_STAGES+1];
	vec_t    chain_vec   [CORDIC_STAGES+1];
	side_t   chain_side  [CORDIC_STAGES+1];
	logic    post_valid;
	result_t post_data;
	logic    res_valid_q;
	result_t res_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;

	// whole pipeline advances while the skid buffer is free
	assign en       = !skid_valid_q;
	assign pt_ready = en;
	assign push     = post_valid & en;

	// angle reduction, fold and gain
	avr_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pt_valid),
		.in_data   (pt_data),
		.out_valid (chain_valid[0]),
		.out_vec   (chain_vec[0]),
		.out_side  (chain_side[0])
	);

	// row of CORDIC cells
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		avr_cell #(
			.STAGE (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[g]),
			.in_vec    (chain_vec[g]),
			.in_side   (chain_side[g]),
			.out_valid (chain_valid[g+1]),
			.out_vec   (chain_vec[g+1]),
			.out_side  (chain_side[g+1])
		);
	end

	// rounding, saturation, reassembly
	avr_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chain_valid[CORDIC_STAGES]),
		.in_vec    (chain_vec[CORDIC_STAGES]),
		.in_side   (chain_side[CORDIC_STAGES]),
		.out_valid (post_valid),
		.out_data  (post_data)
	);

	// output register and skid buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || res_ready) begin
				if (skid_valid_q) begin
					res_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					res_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// output register and skid buffer data
	always_ff @(posedge clk) begin
		if (!res_valid_q || res_ready) begin
			if (skid_valid_q) begin
				res_data_q <= skid_data_q;
			end else if (push) begin
				res_data_q <= post_data;
			end
		end else if (push) begin
			skid_data_q <= post_data;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

`ifndef SYNTHESIS
	// skid buffer only holds data behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid buffer full while output register empty");

	// skid buffer fills only when the output transaction was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid_q && !res_ready))
		else $error("skid buffer filled without an output stall");

	// a stalled pipeline keeps its last stage intact
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && post_valid) |=> ($stable(post_valid) && $stable(post_data)))
		else $error("rounding stage changed during a stall");

	// a clipped transaction carries at least one saturated coordinate
	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.clipped) |->
			(res_data.x_out == SAT_MAX || res_data.x_out == SAT_MIN ||
			 res_data.y_out == SAT_MAX || res_data.y_out == SAT_MIN ||
			 res_data.z_out == SAT_MAX || res_data.z_out == SAT_MIN))
		else $error("clipped set without a saturated coordinate");
`endif

endmodule
